// ----- design/ktbl_pkg.sv -----
// Shared types and constants for the keyed table.
`default_nettype none

package ktbl_pkg;

  localparam int SLOTS_DEFAULT = 64;

  localparam int KEY_W    = 32;
  localparam int VOL_W    = 32;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [SLOT_W-1:0]       slot_index;
    logic signed [VOL_W-1:0] found_volume;
    logic signed [VOL_W-1:0] total_volume;
    logic [COUNT_W-1:0]      entry_count;
  } result_t;

endpackage

`default_nettype wire

// ----- design/ktbl_if.sv -----
// Request and result channel interfaces of the keyed table.
`default_nettype none

interface ktbl_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] key;
  logic signed [31:0] volume;

  modport source (output valid, command, key, volume, input ready);
  modport sink   (input valid, command, key, volume, output ready);
endinterface

interface ktbl_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [5:0]         slot_index;
  logic signed [31:0] found_volume;
  logic signed [31:0] total_volume;
  logic [6:0]         entry_count;

  modport source (output valid, status, slot_index, found_volume, total_volume,
                  entry_count, input ready);
  modport sink   (input valid, status, slot_index, found_volume, total_volume,
                  entry_count, output ready);
endinterface

`default_nettype wire

// ----- design/ktbl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ktbl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/ktbl_ctrl.sv -----
// Command sequencer: add, linear scan for find and remove, swap-with-last move.
`default_nettype none

module ktbl_ctrl #(
  parameter int SLOTS = ktbl_pkg::SLOTS_DEFAULT,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  ktbl_req_if.sink                req,
  output ktbl_pkg::result_t       res,
  output logic                    res_valid,
  input  wire logic               res_take,
  output logic                    ram_we,
  output logic [IDX_W-1:0]        ram_waddr,
  output logic [63:0]             ram_wdata,
  output logic [IDX_W-1:0]        ram_raddr,
  input  wire logic [63:0]        ram_rdata
);

  import ktbl_pkg::*;

  state_t state, state_next;

  logic [1:0]        cmd;
  logic [KEY_W-1:0]  key;
  logic [CNT_W-1:0]  count;
  logic [VOL_W-1:0]  total;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  hit_idx;

  logic              accept;
  logic              full;
  logic              match;
  logic              at_last;
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  count_dec;
  logic [IDX_W-1:0]  last_idx;
  logic [KEY_W-1:0]  rd_key;
  logic [VOL_W-1:0]  rd_vol;
  logic [VOL_W-1:0]  total_add;
  logic [31:0]       count_wide;
  logic [31:0]       count_inc_wide;
  logic [31:0]       count_dec_wide;
  logic [31:0]       rd_wide;
  logic [31:0]       hit_wide;

  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(SLOTS));
  assign count_inc = count + CNT_W'(1);
  assign count_dec = count - CNT_W'(1);
  assign last_idx  = count_dec[IDX_W-1:0];
  assign rd_key    = ram_rdata[63:32];
  assign rd_vol    = ram_rdata[31:0];
  assign match     = (rd_key == key);
  assign at_last   = (rd_idx == last_idx);
  assign total_add = total + req.volume;

  // Widen before masking to the fixed result field widths
  assign count_wide     = 32'(count);
  assign count_inc_wide = 32'(count_inc);
  assign count_dec_wide = 32'(count_dec);
  assign rd_wide        = 32'(rd_idx);
  assign hit_wide       = 32'(hit_idx);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if ((req.command inside {CMD_FIND, CMD_REMOVE}) && count != '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          state_next = (cmd == CMD_REMOVE) ? S_MOVE : S_DONE;
        end else if (at_last) begin
          state_next = S_DONE;
        end
      end
      S_MOVE:  state_next = S_DONE;
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = {req.key, req.volume};
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        ram_we    = req.valid && (req.command == CMD_ADD) && !full;
      end
      S_SCAN: begin
        // Fetch the last entry on a remove hit, else the next slot
        ram_raddr = (match && cmd == CMD_REMOVE) ? last_idx : rd_idx + IDX_W'(1);
      end
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = hit_idx;
        ram_wdata = ram_rdata;
      end
      S_DONE:  res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept && req.command == CMD_ADD && !full) begin
            count <= count_inc;
            total <= total_add;
          end
        end
        S_SCAN: begin
          if (match && cmd == CMD_REMOVE) begin
            total <= total - rd_vol;
          end
        end
        S_MOVE:  count <= count_dec;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd    <= req.command;
          key    <= req.key;
          rd_idx <= '0;
          case (req.command)
            CMD_ADD: begin
              if (full) begin
                res <= '{ST_FULL, '0, '0, total, count_wide[COUNT_W-1:0]};
              end else begin
                res <= '{ST_OK, count_wide[SLOT_W-1:0], '0, total_add,
                         count_inc_wide[COUNT_W-1:0]};
              end
            end
            CMD_FIND, CMD_REMOVE: begin
              res <= '{(count == '0) ? ST_MISS : ST_OK, '0, '0, total,
                       count_wide[COUNT_W-1:0]};
            end
            default: begin
              res <= '{ST_OK, '0, '0, total, count_wide[COUNT_W-1:0]};
            end
          endcase
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_idx <= rd_idx;
          if (cmd == CMD_FIND) begin
            res <= '{ST_OK, rd_wide[SLOT_W-1:0], rd_vol, total,
                     count_wide[COUNT_W-1:0]};
          end
        end else if (at_last) begin
          res <= '{ST_MISS, '0, '0, total, count_wide[COUNT_W-1:0]};
        end else begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
      end
      S_MOVE: begin
        res <= '{ST_OK, hit_wide[SLOT_W-1:0], '0, total,
                 count_dec_wide[COUNT_W-1:0]};
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOTS))
    else $error("entry count exceeds table size");

  a_scan_in_use: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (count != '0 && CNT_W'(rd_idx) < count))
    else $error("scan reached a slot not in use");

  a_move_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == S_MOVE |=> count == $past(count_dec))
    else $error("remove did not shrink the table by one");

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res.status != ST_OK) |->
      (res.slot_index == '0 && res.found_volume == '0))
    else $error("failed command reports a slot or volume");

  a_write_owner: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_MOVE || (state == S_IDLE && !full)))
    else $error("table write outside add or move");
`endif

endmodule

`default_nettype wire

// ----- design/keyed_table_insert_find_remove.sv -----
// Top level of the keyed table: sequencer, table RAM and result register.
`default_nettype none

// Keyed table of SLOTS key/volume entries, packed densely from slot 0 in one
// synchronous RAM. A find or remove scans the slots in use from slot 0 up to
// the hit or to the last entry in use. The scan is set by the single read port
// of the table RAM, one slot per cycle; a remove that hits then copies the last
// entry into the vacated slot in a move state. One command is in flight at a
// time, but the next one is taken while a result still waits in the output
// register. The RAM needs no clearing after reset.
module keyed_table_insert_find_remove #(
  parameter int SLOTS = ktbl_pkg::SLOTS_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  ktbl_req_if.sink  request,
  ktbl_res_if.source result
);

  import ktbl_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  result_t          res;
  logic             res_valid;
  logic             res_take;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [63:0]      ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [63:0]      ram_rdata;

  logic             out_valid;
  result_t          out_word;

  ktbl_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (request),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ktbl_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Load a new word when the register is empty or drains this cycle
  assign res_take = res_valid && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word <= res;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_word.status;
  assign result.slot_index   = out_word.slot_index;
  assign result.found_volume = out_word.found_volume;
  assign result.total_volume = out_word.total_volume;
  assign result.entry_count  = out_word.entry_count;

endmodule

`default_nettype wire
